>>> rtl/core/gpsr_pkg.sv
// Shared types and constants for the GPS rational to microdegrees converter.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none
package gpsr_pkg;

  localparam int unsigned FracBits = 24;
  localparam int unsigned DvdBits  = 32 + FracBits;  // numerator shifted by the fraction bits
  localparam int unsigned DenBits  = 44;             // denominator times 3600 fits here
  localparam int unsigned QueueDepth = 2;

  localparam logic [11:0] MinFactor = 12'd60;
  localparam logic [11:0] SecFactor = 12'd3600;
  localparam logic [19:0] MicroScale = 20'd1000000;

  localparam logic [7:0] HemiSouth = 8'h53;
  localparam logic [7:0] HemiWest  = 8'h57;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusZero = 2'd1;
  localparam logic [1:0] StatusSat  = 2'd2;

  typedef struct packed {
    logic        coordinate_present;
    logic [31:0] degrees_numerator;
    logic [31:0] degrees_denominator;
    logic [31:0] minutes_numerator;
    logic [31:0] minutes_denominator;
    logic [31:0] seconds_numerator;
    logic [31:0] seconds_denominator;
    logic [7:0]  reference_letter;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] micro_degrees;
    logic [1:0]         status;
  } out_item_t;

  // Class of a queued item, decided in the front.
  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_ABSENT = 2'd1,
    KIND_ZERO   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        neg;
    logic [31:0] dn;
    logic [31:0] dd;
    logic [31:0] mn;
    logic [31:0] md;
    logic [31:0] sn;
    logic [31:0] sd;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/core/gpsr_front.sv
// Front part: classifies each accepted item and holds it in a short queue.
// Depends on gpsr_pkg.
`default_nettype none
module gpsr_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  gpsr_pkg::in_item_t  item_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                valid_o,
  output gpsr_pkg::entry_t    head_o
);

  gpsr_pkg::entry_t entry;
  gpsr_pkg::entry_t mem_q [gpsr_pkg::QueueDepth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  // Classify the item: absent first, then any zero denominator.
  always_comb begin
    entry.dn   = item_i.degrees_numerator;
    entry.dd   = item_i.degrees_denominator;
    entry.mn   = item_i.minutes_numerator;
    entry.md   = item_i.minutes_denominator;
    entry.sn   = item_i.seconds_numerator;
    entry.sd   = item_i.seconds_denominator;
    entry.neg  = (item_i.reference_letter == gpsr_pkg::HemiSouth) ||
                 (item_i.reference_letter == gpsr_pkg::HemiWest);
    if (!item_i.coordinate_present) begin
      entry.kind = gpsr_pkg::KIND_ABSENT;
    end else if ((item_i.degrees_denominator == 32'd0) ||
                 (item_i.minutes_denominator == 32'd0) ||
                 (item_i.seconds_denominator == 32'd0)) begin
      entry.kind = gpsr_pkg::KIND_ZERO;
    end else begin
      entry.kind = gpsr_pkg::KIND_NORMAL;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

>>> rtl/core/gpsr_back.sv
// Back part: three-lane restoring divider, scaling, rounding and saturation.
// Depends on gpsr_pkg.
`default_nettype none
module gpsr_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  input  gpsr_pkg::entry_t    head_i,
  output logic                pop_o,
  output logic                done_o,
  output gpsr_pkg::out_item_t result_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SUM  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  localparam int unsigned RemBits = gpsr_pkg::DenBits;
  localparam int unsigned SumBits = gpsr_pkg::DvdBits + 2;

  state_e state_q, state_d;
  logic [5:0] cnt_q;
  logic       neg_q;
  logic [gpsr_pkg::DvdBits-1:0] dvd_q [3];
  logic [gpsr_pkg::DvdBits-1:0] quo_q [3];
  logic [RemBits-1:0]           rem_q [3];
  logic [gpsr_pkg::DenBits-1:0] den_q [3];
  logic [SumBits-1:0] sum_q;
  logic [53:0] whole_q;
  logic [43:0] part_q;
  logic        done_q;
  gpsr_pkg::out_item_t res_q;

  logic [RemBits:0] trial [3];
  logic             qbit  [3];
  logic [54:0] mag, mag_r;
  logic [23:0] frac;
  logic        rnd_up;

  // One quotient bit per lane per cycle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_q[i], dvd_q[i][gpsr_pkg::DvdBits-1]};
      qbit[i]  = (trial[i] >= {1'b0, den_q[i]});
    end
  end

  // Scale, round half to even.
  always_comb begin
    mag    = {1'b0, whole_q} + {35'd0, part_q[43:24]};
    frac   = part_q[23:0];
    rnd_up = (frac > 24'h800000) || ((frac == 24'h800000) && mag[0]);
    mag_r  = mag + {54'd0, rnd_up};
  end

  assign pop_o = (state_q == S_IDLE) && valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (valid_i && (head_i.kind == gpsr_pkg::KIND_NORMAL)) state_d = S_DIV;
      S_DIV:  if (cnt_q == 6'(gpsr_pkg::DvdBits - 1)) state_d = S_SUM;
      S_SUM:  state_d = S_MUL;
      S_MUL:  state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 6'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (pop_o && (head_i.kind != gpsr_pkg::KIND_NORMAL)) || (state_q == S_FIN);
      if (state_q == S_DIV) cnt_q <= cnt_q + 6'd1;
      else                  cnt_q <= 6'd0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q    <= head_i.neg;
      dvd_q[0] <= {head_i.dn, 24'd0};
      dvd_q[1] <= {head_i.mn, 24'd0};
      dvd_q[2] <= {head_i.sn, 24'd0};
      den_q[0] <= {12'd0, head_i.dd};
      den_q[1] <= 44'({12'd0, head_i.md} * {32'd0, gpsr_pkg::MinFactor});
      den_q[2] <= 44'({12'd0, head_i.sd} * {32'd0, gpsr_pkg::SecFactor});
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= '0;
        quo_q[i] <= '0;
      end
      res_q.micro_degrees <= '0;
      res_q.status <= (head_i.kind == gpsr_pkg::KIND_ZERO) ?
                      gpsr_pkg::StatusZero : gpsr_pkg::StatusOk;
    end
    if (state_q == S_DIV) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= qbit[i] ? RemBits'(trial[i] - {1'b0, den_q[i]}) : RemBits'(trial[i]);
        quo_q[i] <= {quo_q[i][gpsr_pkg::DvdBits-2:0], qbit[i]};
        dvd_q[i] <= {dvd_q[i][gpsr_pkg::DvdBits-2:0], 1'b0};
      end
    end
    if (state_q == S_SUM) begin
      sum_q <= {2'd0, quo_q[0]} + {2'd0, quo_q[1]} + {2'd0, quo_q[2]};
    end
    if (state_q == S_MUL) begin
      whole_q <= 54'(sum_q[SumBits-1:24] * gpsr_pkg::MicroScale);
      part_q  <= 44'(sum_q[23:0] * gpsr_pkg::MicroScale);
    end
    if (state_q == S_FIN) begin
      if (neg_q && (mag_r > 55'h80000000)) begin
        res_q.micro_degrees <= 32'sh80000000;
        res_q.status        <= gpsr_pkg::StatusSat;
      end else if (!neg_q && (mag_r > 55'h7FFFFFFF)) begin
        res_q.micro_degrees <= 32'sh7FFFFFFF;
        res_q.status        <= gpsr_pkg::StatusSat;
      end else begin
        res_q.micro_degrees <= neg_q ? -$signed(mag_r[31:0]) : $signed(mag_r[31:0]);
        res_q.status        <= gpsr_pkg::StatusOk;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A result follows either a finish step or a pop of a special item.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_FIN) || ($past(state_q) == S_IDLE))
    else $error("result without a finished item");
  // A zero denominator result is always zero.
  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == gpsr_pkg::StatusZero)) |-> (res_q.micro_degrees == 32'sd0))
    else $error("zero denominator result not zero");
  // Saturation only gives an extreme value.
  a_sat_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (res_q.status == gpsr_pkg::StatusSat)) |->
      ((res_q.micro_degrees == 32'sh7FFFFFFF) || (res_q.micro_degrees == 32'sh80000000)))
    else $error("saturated result not at a limit");
  // Nothing leaves the queue while a division runs.
  a_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !pop_o)
    else $error("pop while busy");

endmodule
`default_nettype wire

>>> rtl/core/gps_rational_to_microdegrees_top.sv
// Top level of the GPS rational to microdegrees converter: front queue and back unit.
// Depends on gpsr_pkg, gpsr_front and gpsr_back.
// An absent or zero-denominator item gives its result through the done register; a normal
// item goes through the 56-step restoring divider, then the sum, multiply and finish states.
// The back takes a new item only when idle; the two-entry queue takes items meanwhile.
// Reset is asynchronous and active low and empties the queue; results cannot be stalled.
`default_nettype none
module gps_rational_to_microdegrees_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  gpsr_pkg::in_item_t  item_i,
  output logic                done_o,
  output gpsr_pkg::out_item_t result_o
);

  logic             push, pop, full, valid;
  gpsr_pkg::entry_t head;

  assign push = start && !full;
  assign busy = full;

  gpsr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_i),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (valid),
    .head_o  (head)
  );

  gpsr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid),
    .head_i   (head),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire
